### sv/tspa_pkg.sv
// ----------------------------------------------------------------------------
// tspa_pkg
// Shared widths, register indexes, tiling mode codes and pipeline types for
// the tiled surface page address unit.
// ----------------------------------------------------------------------------
package tspa_pkg;

  localparam int unsigned PAGE_BYTES = 4096;
  localparam int unsigned PAGE_LOG   = $clog2(PAGE_BYTES);

  localparam int unsigned X_W      = 17;
  localparam int unsigned Y_W      = 17;
  localparam int unsigned OFF_W    = 32;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned BPP_W    = 5;
  localparam int unsigned STRIDE_W = 19;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W    = STRIDE_W;
  localparam int unsigned SHIFT_W  = 3;
  localparam int unsigned LOG_W    = 4;
  localparam int unsigned MUL_W    = Y_W + STRIDE_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILING_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BPP         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_STRIDE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEN2        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEGACY_Y    = 3'd4;

  // Tiling modes
  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_X      = 2'd1;
  localparam logic [MODE_W-1:0] MODE_Y      = 2'd2;
  localparam logic [MODE_W-1:0] MODE_YF     = 2'd3;

  // log2 of tile widths in bytes
  localparam logic [LOG_W-1:0] WLOG_64  = 4'd6;
  localparam logic [LOG_W-1:0] WLOG_128 = 4'd7;
  localparam logic [LOG_W-1:0] WLOG_256 = 4'd8;
  localparam logic [LOG_W-1:0] WLOG_512 = 4'd9;
  localparam logic [LOG_W-1:0] WLOG_PAGE = LOG_W'(PAGE_LOG);

  // Reset values
  localparam logic [BPP_W-1:0]    BPP_RST    = 5'd4;
  localparam logic [STRIDE_W-1:0] STRIDE_RST = 19'd4096;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [BPP_W-1:0]    bpp;
    logic [STRIDE_W-1:0] stride;
    logic                gen2;
    logic                legacy_y;
  } cfg_t;

  // One item as it travels down the pipeline
  typedef struct packed {
    logic               lin;
    logic               bad;
    logic [SHIFT_W-1:0] bshift;
    logic [OFF_W-1:0]   offset;
    logic [POS_W-1:0]   rem;
    logic [POS_W-1:0]   num;
    logic [POS_W-1:0]   quo;
    logic [POS_W-1:0]   tix;
    logic [POS_W-1:0]   tiy;
  } item_t;

endpackage

### sv/tspa_addr_gen.sv
// ----------------------------------------------------------------------------
// tspa_addr_gen
// Three-stage front end: format decode, row multiply, offset add and page
// split.
// ----------------------------------------------------------------------------
module tspa_addr_gen (
  input  logic                      clk,
  input  logic                      rst_n,
  input  tspa_pkg::cfg_t            cfg,
  input  logic                      up_valid,
  input  logic [tspa_pkg::X_W-1:0]  pixel_x,
  input  logic [tspa_pkg::Y_W-1:0]  pixel_y,
  output logic                      up_ready,
  output logic                      valid,
  output tspa_pkg::item_t           item,
  input  logic                      down_ready
);
  import tspa_pkg::*;

  logic               bad;
  logic [SHIFT_W-1:0] bshift;
  logic [LOG_W-1:0]   wlog;
  logic [LOG_W-1:0]   thlog;
  logic [LOG_W-1:0]   twlog;
  logic [Y_W-1:0]     ymask;
  logic [X_W-1:0]     xmask;
  logic               lin;
  item_t              item1_nxt;
  logic [Y_W-1:0]     a1_nxt;

  logic               v1_r, v2_r, v3_r;
  logic               en1, en2, en3;
  item_t              item1_r, item2_r, item3_r, item3_nxt;
  logic [Y_W-1:0]     a1_r;
  logic [MUL_W-1:0]   prod_full;
  logic [OFF_W-1:0]   prod2_r;
  logic [OFF_W-1:0]   sum;

  always_comb begin
    bad    = 1'b0;
    bshift = '0;
    unique case (cfg.bpp)
      5'd1:    bshift = 3'd0;
      5'd2:    bshift = 3'd1;
      5'd4:    bshift = 3'd2;
      5'd8:    bshift = 3'd3;
      5'd16:   bshift = 3'd4;
      default: bad    = 1'b1;
    endcase

    unique case (cfg.mode)
      MODE_X:  wlog = cfg.gen2 ? WLOG_256 : WLOG_512;
      MODE_Y:  wlog = cfg.gen2 ? WLOG_256 : (cfg.legacy_y ? WLOG_512 : WLOG_128);
      MODE_YF: wlog = (cfg.bpp == 5'd1) ? WLOG_64 :
                      ((cfg.bpp <= 5'd4) ? WLOG_128 : WLOG_256);
      default: wlog = WLOG_PAGE;
    endcase

    lin   = (cfg.mode == MODE_LINEAR);
    thlog = WLOG_PAGE - wlog;
    twlog = wlog - LOG_W'(bshift);
    ymask = (Y_W'(1) << thlog) - Y_W'(1);
    xmask = (X_W'(1) << twlog) - X_W'(1);

    item1_nxt        = '0;
    item1_nxt.lin    = lin;
    item1_nxt.bad    = bad;
    item1_nxt.bshift = bshift;
    item1_nxt.tix    = POS_W'(pixel_x & xmask);
    item1_nxt.tiy    = POS_W'(pixel_y & ymask);
    if (lin) begin
      item1_nxt.offset = OFF_W'(pixel_x) << bshift;
      a1_nxt           = pixel_y;
    end else begin
      item1_nxt.offset = OFF_W'(pixel_x >> twlog) << PAGE_LOG;
      a1_nxt           = pixel_y & ~ymask;
    end
  end

  assign en3      = !v3_r || down_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  assign prod_full = MUL_W'(a1_r) * MUL_W'(cfg.stride);

  always_comb begin
    sum       = item2_r.offset + prod2_r;
    item3_nxt = item2_r;
    item3_nxt.rem = '0;
    item3_nxt.quo = '0;
    if (item2_r.lin) begin
      item3_nxt.offset = {sum[OFF_W-1:PAGE_LOG], {PAGE_LOG{1'b0}}};
      item3_nxt.num    = sum[POS_W-1:0];
    end else begin
      item3_nxt.offset = sum;
      item3_nxt.num    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= up_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item1_r <= item1_nxt;
      a1_r    <= a1_nxt;
    end
    if (en2) begin
      item2_r <= item1_r;
      prod2_r <= prod_full[OFF_W-1:0];
    end
    if (en3) item3_r <= item3_nxt;
  end

  assign valid = v3_r;
  assign item  = item3_r;

endmodule

### sv/tspa_div_stage.sv
// ----------------------------------------------------------------------------
// tspa_div_stage
// One restoring step of the in-page row divide: shift in a dividend bit,
// compare with the stride, subtract and record a quotient bit.
// ----------------------------------------------------------------------------
module tspa_div_stage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [tspa_pkg::STRIDE_W-1:0] stride,
  input  logic                          up_valid,
  input  tspa_pkg::item_t               up_item,
  output logic                          up_ready,
  output logic                          valid,
  output tspa_pkg::item_t               item,
  input  logic                          down_ready
);
  import tspa_pkg::*;

  logic [POS_W:0]      trial;
  logic [STRIDE_W-1:0] diff;
  logic                ge;
  item_t               item_nxt;
  item_t               item_r;
  logic                valid_r;
  logic                en;

  always_comb begin
    trial    = {up_item.rem, up_item.num[POS_W-1]};
    ge       = STRIDE_W'(trial) >= stride;
    diff     = STRIDE_W'(trial) - stride;
    item_nxt = up_item;
    item_nxt.rem = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
    item_nxt.num = up_item.num << 1;
    item_nxt.quo = {up_item.quo[POS_W-2:0], ge};
  end

  assign en       = !valid_r || down_ready;
  assign up_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) item_r <= item_nxt;
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

### sv/tiled_surface_page_address_unit.sv
// ----------------------------------------------------------------------------
// tiled_surface_page_address_unit
// Maps a pixel coordinate to the byte offset of its 4 KiB page or tile and
// the pixel's column and row inside it, for linear, X, Y and Yf surfaces.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per pixel; tdata = pixel_x, pixel_y.
//   out_* : one beat per input beat, in order; tdata = page_offset,
//           in_page_x, in_page_y; tuser = bad_format.
//   cfg_* : register writes (tiling mode, bytes per pixel, row stride,
//           gen2 layout, legacy Y layout), done while no beat is in flight.
// An input beat passes through decode, multiply, add and page split, twelve
// restoring divide steps for the in-page row in linear mode, and the output
// register. Throughput is one beat per cycle until back-pressure fills every
// stage; the divide is a twelve-stage pipeline, one quotient bit per stage.
// Each stage holds its own valid bit, so a bubble anywhere is squeezed out
// and input beats keep flowing while a result waits at the output; in_tready
// drops only once every stage is full and out_tready is low. Nothing is lost
// or repeated under stall. Reset empties the pipeline and loads the register
// reset values (linear, 4 bytes per pixel, stride 4096).
// ----------------------------------------------------------------------------
module tiled_surface_page_address_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [39:0]                    in_tdata,   // pixel_x[16:0], pixel_y[33:17]
  // Result stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [55:0]                    out_tdata,  // page_offset[31:0],
                                                     // in_page_x[43:32],
                                                     // in_page_y[55:44]
  output logic                           out_tuser,  // bad_format
  // Register writes
  input  logic                           cfg_we,
  input  logic [tspa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tspa_pkg::CFG_W-1:0]     cfg_wdata
);
  import tspa_pkg::*;

  cfg_t           cfg_r;
  item_t          div_item  [0:POS_W];
  logic [POS_W:0] div_valid;
  logic [POS_W:0] div_ready;
  item_t          last;

  logic                     out_valid_r;
  logic [55:0]              out_tdata_r, out_tdata_nxt;
  logic                     out_tuser_r, out_tuser_nxt;
  logic                     out_en;
  logic [POS_W-1:0]         ix, iy;

  // Register file: write-only, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode     <= MODE_LINEAR;
      cfg_r.bpp      <= BPP_RST;
      cfg_r.stride   <= STRIDE_RST;
      cfg_r.gen2     <= 1'b0;
      cfg_r.legacy_y <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TILING_MODE: cfg_r.mode     <= cfg_wdata[MODE_W-1:0];
        REG_BPP:         cfg_r.bpp      <= cfg_wdata[BPP_W-1:0];
        REG_ROW_STRIDE:  cfg_r.stride   <= cfg_wdata[STRIDE_W-1:0];
        REG_GEN2:        cfg_r.gen2     <= cfg_wdata[0];
        REG_LEGACY_Y:    cfg_r.legacy_y <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Front end: decode, multiply, add
  tspa_addr_gen u_addr_gen (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .up_valid   (in_tvalid),
    .pixel_x    (in_tdata[X_W-1:0]),
    .pixel_y    (in_tdata[X_W+Y_W-1:X_W]),
    .up_ready   (in_tready),
    .valid      (div_valid[0]),
    .item       (div_item[0]),
    .down_ready (div_ready[0])
  );

  // Row divide: one quotient bit per stage
  for (genvar k = 0; k < POS_W; k++) begin : g_div
    tspa_div_stage u_div (
      .clk        (clk),
      .rst_n      (rst_n),
      .stride     (cfg_r.stride),
      .up_valid   (div_valid[k]),
      .up_item    (div_item[k]),
      .up_ready   (div_ready[k]),
      .valid      (div_valid[k+1]),
      .item       (div_item[k+1]),
      .down_ready (div_ready[k+1])
    );
  end

  assign last           = div_item[POS_W];
  assign out_en         = !out_valid_r || out_tready;
  assign div_ready[POS_W] = out_en;

  // Pick the in-page position; the remainder is bytes, so shift down by bpp
  always_comb begin
    if (last.lin) begin
      iy = (cfg_r.stride == '0) ? '0 : last.quo;
      ix = last.rem >> last.bshift;
    end else begin
      iy = last.tiy;
      ix = last.tix;
    end
    if (last.bad) begin
      out_tdata_nxt = '0;
      out_tuser_nxt = 1'b1;
    end else begin
      out_tdata_nxt = {iy, ix, last.offset};
      out_tuser_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= div_valid[POS_W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

### sv/tspa_checker.sv
// ----------------------------------------------------------------------------
// tspa_checker
// Port-level checks on the page address unit, bound to the top level.
// ----------------------------------------------------------------------------
module tspa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic        out_tuser
);

  // A rejected format carries an all-zero address
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("bad_format beat with nonzero address");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // Back-pressure reaches the input only from a stalled output
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled while output free");

endmodule

bind tiled_surface_page_address_unit tspa_checker u_tspa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
